// File: rtl/gpvp_pkg.sv
// ----------------------------------------------------------------------------
// gpvp_pkg
// Shared types, constants and speed profile tables of the grid path velocity
// profiler.
// ----------------------------------------------------------------------------
package gpvp_pkg;

  localparam int COORD_W     = 8;
  localparam int SPEED_W     = 6;
  localparam int SLOT_W      = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int CRUISE_SLOTS_PER_CELL = 10;
  localparam int CRUISE_W = $clog2(CRUISE_SLOTS_PER_CELL + 1);
  localparam int PROD_W   = (COORD_W + CRUISE_W > SLOT_W) ? COORD_W + CRUISE_W : SLOT_W;
  localparam int SLOT_MAX = (1 << SLOT_W) - 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SHORT_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_RAMP_TOP   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_CRUISE     = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_LONG_LAST  = STEP_W'(8);

  localparam logic [SPEED_W-1:0] V_05 = SPEED_W'(5);
  localparam logic [SPEED_W-1:0] V_10 = SPEED_W'(10);
  localparam logic [SPEED_W-1:0] V_15 = SPEED_W'(15);
  localparam logic [SPEED_W-1:0] V_20 = SPEED_W'(20);
  localparam logic [SPEED_W-1:0] V_25 = SPEED_W'(25);

  localparam logic [SLOT_W-1:0] RAMP_SLOTS = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] PEAK_SLOTS = SLOT_W'(10);

  typedef struct packed {
    logic              long_leg;
    logic              has_cruise;
    logic              neg_x;
    logic              nz_x;
    logic              neg_y;
    logic              nz_y;
    logic [SLOT_W-1:0] cruise_slots;
  } leg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [SPEED_W-1:0] seg_speed(input logic long_leg,
                                                   input logic [STEP_W-1:0] step);
    logic [SPEED_W-1:0] v;
    v = V_05;
    if (!long_leg) begin
      v = (step == STEP_W'(1)) ? V_15 : V_10;
    end else begin
      case (step)
        STEP_W'(0): v = V_05;
        STEP_W'(1): v = V_10;
        STEP_W'(2): v = V_15;
        STEP_W'(3): v = V_20;
        STEP_W'(4): v = V_25;
        STEP_W'(5): v = V_20;
        STEP_W'(6): v = V_15;
        STEP_W'(7): v = V_10;
        default:    v = V_05;
      endcase
    end
    return v;
  endfunction

  function automatic logic [SLOT_W-1:0] seg_slots(input logic long_leg,
                                                  input logic [STEP_W-1:0] step,
                                                  input logic [SLOT_W-1:0] cruise);
    logic [SLOT_W-1:0] s;
    s = RAMP_SLOTS;
    if (!long_leg) begin
      s = (step == STEP_W'(1)) ? PEAK_SLOTS : RAMP_SLOTS;
    end else if (step == STEP_CRUISE) begin
      s = cruise;
    end
    return s;
  endfunction

  function automatic logic [SPEED_W-1:0] apply_dir(input logic neg, input logic nz,
                                                   input logic [SPEED_W-1:0] mag);
    logic [SPEED_W-1:0] r;
    r = '0;
    if (nz) begin
      r = neg ? SPEED_W'(~mag + 1'b1) : mag;
    end
    return r;
  endfunction

endpackage

// File: rtl/gpvp_front.sv
// ----------------------------------------------------------------------------
// gpvp_front
// Takes waypoints, keeps the previous one and turns each real leg into a
// leg descriptor for the segment queue.
// ----------------------------------------------------------------------------
module gpvp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gpvp_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [0:0]                       s_tuser,
  input  gpvp_pkg::q_stat_t                q_stat,
  output logic                             push,
  output gpvp_pkg::leg_t                   push_leg
);
  import gpvp_pkg::*;

  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic               have_prev;

  logic [COORD_W-1:0] x, y, adx, ady, leg_len, leg_len_m2;
  logic [PROD_W-1:0]  prod;
  logic               start, accept;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign x        = s_tdata[COORD_W-1:0];
  assign y        = s_tdata[2*COORD_W-1:COORD_W];
  assign start    = s_tuser[0];

  always_comb begin
    adx        = (x >= prev_x) ? x - prev_x : prev_x - x;
    ady        = (y >= prev_y) ? y - prev_y : prev_y - y;
    leg_len    = (x != prev_x) ? adx : ady;
    leg_len_m2 = leg_len - COORD_W'(2);
    prod       = PROD_W'(leg_len_m2) * PROD_W'(CRUISE_SLOTS_PER_CELL);

    push_leg.long_leg     = (leg_len != COORD_W'(1));
    push_leg.has_cruise   = (leg_len > COORD_W'(2));
    push_leg.neg_x        = (x < prev_x);
    push_leg.nz_x         = (x != prev_x);
    push_leg.neg_y        = (y < prev_y);
    push_leg.nz_y         = (y != prev_y);
    push_leg.cruise_slots = (prod > PROD_W'(SLOT_MAX)) ? SLOT_W'(SLOT_MAX) : SLOT_W'(prod);

    push = accept && have_prev && !start && ((x != prev_x) || (y != prev_y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (accept) begin
      prev_x    <= x;
      prev_y    <= y;
      have_prev <= 1'b1;
    end
  end

endmodule

// File: rtl/gpvp_queue.sv
// ----------------------------------------------------------------------------
// gpvp_queue
// Short queue of leg descriptors between the waypoint front end and the
// segment sequencer.
// ----------------------------------------------------------------------------
module gpvp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gpvp_pkg::leg_t    push_leg,
  input  logic              pop,
  output gpvp_pkg::leg_t    head_leg,
  output gpvp_pkg::q_stat_t q_stat
);
  import gpvp_pkg::*;

  leg_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head_leg     = mem[rd_ptr];
  assign q_stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_leg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/gpvp_back.sv
// ----------------------------------------------------------------------------
// gpvp_back
// Steps through the speed profile of the leg at the head of the queue and
// presents one segment per cycle in the output register, while the queue holds a leg and the output is not stalled.
// ----------------------------------------------------------------------------
module gpvp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  gpvp_pkg::leg_t                    head_leg,
  input  gpvp_pkg::q_stat_t                 q_stat,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gpvp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);
  import gpvp_pkg::*;

  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic               load, last_step;
  logic [SPEED_W-1:0] mag, vx, vy;
  logic [SLOT_W-1:0]  slots;

  always_comb begin
    load      = !q_stat.empty && (!m_tvalid || m_tready);
    last_step = head_leg.long_leg ? (step == STEP_LONG_LAST) : (step == STEP_SHORT_LAST);
    pop       = load && last_step;
    mag       = seg_speed(head_leg.long_leg, step);
    slots     = seg_slots(head_leg.long_leg, step, head_leg.cruise_slots);
    vx        = apply_dir(head_leg.neg_x, head_leg.nz_x, mag);
    vy        = apply_dir(head_leg.neg_y, head_leg.nz_y, mag);
    step_next = step + 1'b1;
    if (last_step) begin
      step_next = '0;
    end else if (head_leg.long_leg && !head_leg.has_cruise && step == STEP_RAMP_TOP) begin
      step_next = STEP_CRUISE + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        step     <= step_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {slots, vy, vx};
      m_tlast <= last_step;
    end
  end

endmodule

// File: rtl/grid_path_velocity_profiler.sv
// ----------------------------------------------------------------------------
// grid_path_velocity_profiler
// Turns a stream of grid waypoints into constant-velocity speed segments.
// ----------------------------------------------------------------------------
// An accepted waypoint's leg is written into the leg queue; its first segment
// then passes through the output register before it is valid on the output.
// The sequencer emits one segment per cycle while the output is not stalled: a leg gives 3, 8 or 9 segments.
// Path starts and repeated waypoints are accepted and emit nothing.
// Synchronous reset clears the previous waypoint, the queue and output valid.
module grid_path_velocity_profiler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // grid_x [7:0], grid_y [15:8]
  input  logic [gpvp_pkg::IN_TDATA_W-1:0]   s_tdata,
  // path_start [0]
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // speed_x [5:0], speed_y [11:6], slot_count [23:12]
  output logic [gpvp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);
  import gpvp_pkg::*;

  q_stat_t q_stat;
  leg_t    push_leg;
  leg_t    head_leg;
  logic    push;
  logic    pop;

  gpvp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_leg (push_leg)
  );

  gpvp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_leg (push_leg),
    .pop      (pop),
    .head_leg (head_leg),
    .q_stat   (q_stat)
  );

  gpvp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_leg (head_leg),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("leg queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("leg queue pushed while full");

  a_segment_moves: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[SPEED_W-1:0] != '0 || m_tdata[2*SPEED_W-1:SPEED_W] != '0))
    else $error("segment with zero velocity on both axes");

  a_segment_slots: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_TDATA_W-1:2*SPEED_W] != '0))
    else $error("segment with zero slot count");
`endif

endmodule
